@@ rtl/polynomial_signal_predictor_corrector_assert.svh @@
// Assertion macros for the predictor / corrector.
`ifndef POLYNOMIAL_SIGNAL_PREDICTOR_CORRECTOR_ASSERT_SVH
`define POLYNOMIAL_SIGNAL_PREDICTOR_CORRECTOR_ASSERT_SVH

`define PSPC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

`define PSPC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ rtl/pspc_pkg.sv @@
`default_nettype none
package pspc_pkg;
  localparam int NUM_DOF = 8;
  localparam int DOF_W = 3;
  localparam int ADDR_W = (NUM_DOF > 1) ? $clog2(NUM_DOF) : 1;
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_FILL = 2'd1;
  localparam logic [1:0] FUNC_PREDICT = 2'd2;
  localparam logic [1:0] FUNC_CORRECT = 2'd3;
  localparam logic [16:0] FRAC_ONE = 17'd65536;

  typedef logic signed [31:0] tap_t;
  typedef tap_t [3:0] row_t;

  typedef struct packed {
    logic [1:0] func;
    logic [16:0] frac;
    logic [1:0] order;
    logic        inrange;
  } job_t;
endpackage
`default_nettype wire

@@ rtl/polynomial_signal_predictor_corrector.sv @@
`default_nettype none
// Four-tap Lagrange predictor / corrector over NUM_DOF histories held in one
// synchronous RAM row per degree of freedom; rows read as zero until first
// written after reset. Push and fill read the row and write it back before
// the next request is taken. Predict and correct raise result_valid after a
// row read, the three weight stages, the MAC (eight half-width products,
// rounding, a two-step reciprocal divide by 6 and clamping), a state that
// sees the MAC finish and the load of the output register, where the result
// waits while an earlier result has not been taken. One request is processed
// at a time.
module polynomial_signal_predictor_corrector (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  output logic                    ready,
  input  wire logic [1:0]         func,
  input  wire logic [2:0]         dof_index,
  input  wire logic signed [31:0] sample_value,
  input  wire logic [16:0]        fraction,
  input  wire logic [1:0]         poly_order,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic signed [31:0]      result_value,
  output logic                    saturated
);
  import pspc_pkg::*;
  `include "polynomial_signal_predictor_corrector_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_WR = 3'd2, S_W = 3'd3,
    S_MAC = 3'd4, S_OUT = 3'd5;
  logic [2:0] state;
  logic [1:0] wait_cnt;
  job_t job;
  tap_t sample;
  logic [ADDR_W-1:0] addr;
  row_t rdata, wdata, taps, rd_row;
  logic [NUM_DOF-1:0] row_vld;
  logic we, mac_start, mac_done, mac_sat, out_load;
  logic signed [31:0] mac_val;
  logic signed [56:0] w0, w1, w2, w3;
  logic [16:0] frac_c;

  assign ready = (state == S_IDLE);
  assign frac_c = (fraction > FRAC_ONE) ? FRAC_ONE : fraction;
  assign rd_row = row_vld[addr] ? rdata : '0;
  assign out_load = (state == S_OUT) && (!result_valid || result_ready);

  always_comb begin
    if (job.func == FUNC_PUSH) wdata = {rd_row[2], rd_row[1], rd_row[0], sample};
    else wdata = {sample, sample, sample, sample};
  end
  assign we = (state == S_WR) && job.inrange;

  pspc_history_ram u_ram (.clk(clk), .we(we), .waddr(addr), .wdata(wdata),
    .raddr(addr), .rdata(rdata));

  pspc_weights u_w (.clk(clk), .corr(job.func == FUNC_CORRECT),
    .order(job.order), .frac(job.frac), .w0(w0), .w1(w1), .w2(w2), .w3(w3));

  assign mac_start = (state == S_W) && (wait_cnt == 2'd3);
  pspc_mac u_mac (.clk(clk), .rst(rst), .start(mac_start), .taps(taps),
    .w0(w0), .w1(w1), .w2(w2), .w3(w3), .done(mac_done), .value(mac_val),
    .sat(mac_sat));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      wait_cnt <= '0;
      row_vld <= '0;
    end else begin
      if (out_load) result_valid <= 1'b1;
      else if (result_valid && result_ready) result_valid <= 1'b0;
      if (we) row_vld[addr] <= 1'b1;
      unique case (state)
        S_IDLE: if (valid && ready) begin
          job.func <= func;
          job.frac <= frac_c;
          job.order <= poly_order;
          job.inrange <= 32'(dof_index) < NUM_DOF;
          addr <= ADDR_W'(dof_index);
          sample <= sample_value;
          state <= S_RD;
        end
        S_RD: begin
          if (!job.func[1]) state <= S_WR;
          else begin
            state <= S_W;
            wait_cnt <= '0;
          end
        end
        S_WR: state <= S_IDLE;
        S_W: begin
          if (wait_cnt == 2'd0) taps <= rd_row;
          if (wait_cnt == 2'd3) state <= S_MAC;
          wait_cnt <= wait_cnt + 2'd1;
        end
        S_MAC: if (mac_done) state <= S_OUT;
        S_OUT: if (out_load) begin
          result_value <= job.inrange ? mac_val : '0;
          saturated <= job.inrange ? mac_sat : 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSPC_ASSERT_IMP(a_ready_idle, clk, rst, ready, state == S_IDLE)
  `PSPC_ASSERT_NEXT(a_done_out, clk, rst, mac_done && state == S_MAC, state == S_OUT)
  `PSPC_ASSERT_IMP(a_no_write_pred, clk, rst, we, !job.func[1])
endmodule
`default_nettype wire

@@ rtl/pspc_history_ram.sv @@
`default_nettype none
module pspc_history_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [pspc_pkg::ADDR_W-1:0] waddr,
  input  wire pspc_pkg::row_t             wdata,
  input  wire logic [pspc_pkg::ADDR_W-1:0] raddr,
  output pspc_pkg::row_t                  rdata
);
  import pspc_pkg::*;
  row_t mem [NUM_DOF];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/pspc_weights.sv @@
`default_nettype none
// Computes the four Lagrange weight numerators (units of 1/(6*2^48)).
// Three products in the second stage; the weights leave the third stage
// registered.
module pspc_weights (
  input  wire logic                  clk,
  input  wire logic                  corr,
  input  wire logic [1:0]            order,
  input  wire logic [16:0]           frac,
  output logic signed [56:0]         w0,
  output logic signed [56:0]         w1,
  output logic signed [56:0]         w2,
  output logic signed [56:0]         w3
);
  import pspc_pkg::*;
  logic [18:0] a, b, c, m, f;
  logic [37:0] p1, p2, p3;
  logic [1:0] ord_q, ord_q2;
  logic corr_q, corr_q2;
  logic [18:0] f_q, a_q, b_q, m_q;
  logic signed [56:0] t1, t2, t3, t4;

  always_ff @(posedge clk) begin
    a <= 19'(frac) + 19'd65536;
    b <= 19'(frac) + 19'd131072;
    c <= 19'(frac) + 19'd196608;
    m <= 19'd65536 - 19'(frac);
    f <= 19'(frac);
    ord_q <= order;
    corr_q <= corr;
    // stage 2: pairwise products
    if (corr_q) begin
      p1 <= 38'(a) * 38'(b);
      p2 <= 38'(f) * 38'(a);
      p3 <= 38'(m) * 38'(f);
    end else begin
      p1 <= 38'(a) * 38'(b);
      p2 <= 38'(b) * 38'(c);
      p3 <= 38'(a) * 38'(c);
    end
    f_q <= f; a_q <= a; b_q <= b; m_q <= m;
    ord_q2 <= ord_q;
    corr_q2 <= corr_q;
  end

  // stage 3: final weights
  always_comb begin
    t1 = '0; t2 = '0; t3 = '0; t4 = '0;
    if (!corr_q2) begin
      unique case (ord_q2)
        2'd0: t1 = 57'sd6 <<< 48;
        2'd1: begin
          t1 = 57'(6 * (76'(a_q) << 32));
          t2 = -57'(6 * (76'(f_q) << 32));
        end
        2'd2: begin
          t1 = 57'(3 * (76'(p1) << 16));
          t2 = -57'(6 * ((76'(f_q) * 76'(b_q)) << 16));
          t3 = 57'(3 * ((76'(f_q) * 76'(a_q)) << 16));
        end
        default: begin
          t1 = 57'(76'(p1) * 76'(b_q + 19'd65536));
          t2 = -57'(3 * 76'(f_q) * 76'(p2));
          t3 = 57'(3 * 76'(f_q) * 76'(p3));
          t4 = -57'(76'(f_q) * 76'(p1));
        end
      endcase
    end else begin
      unique case (ord_q2)
        2'd0: t1 = 57'sd6 <<< 48;
        2'd1: begin
          t1 = 57'(6 * (76'(f_q) << 32));
          t2 = 57'(6 * (76'(m_q) << 32));
        end
        2'd2: begin
          t1 = 57'(3 * (76'(p2) << 16));
          t2 = 57'(6 * ((76'(m_q) * 76'(a_q)) << 16));
          t3 = -57'(3 * (76'(p3) << 16));
        end
        default: begin
          t1 = 57'(76'(f_q) * 76'(p1));
          t2 = 57'(3 * 76'(m_q) * 76'(p1));
          t3 = -57'(3 * 76'(p3) * 76'(b_q));
          t4 = 57'(76'(p3) * 76'(a_q));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    w0 <= t1; w1 <= t2; w2 <= t3; w3 <= t4;
  end
endmodule
`default_nettype wire

@@ rtl/pspc_mac.sv @@
`default_nettype none
// Multiply-accumulate of taps by weights, one half weight per cycle (low 29
// bits, then the signed upper 28), then rounding, floor division by 6 through
// a reciprocal multiply in two halves, and clamping.
module pspc_mac (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire pspc_pkg::row_t       taps,
  input  wire logic signed [56:0]   w0,
  input  wire logic signed [56:0]   w1,
  input  wire logic signed [56:0]   w2,
  input  wire logic signed [56:0]   w3,
  output logic                      done,
  output logic signed [31:0]        value,
  output logic                      sat
);
  import pspc_pkg::*;
  localparam logic [33:0] RECIP_3 = 34'd11453246123;
  localparam logic signed [47:0] SAT_BOUND = 48'sd12884901888;
  logic [3:0] step;
  logic busy;
  logic signed [95:0] acc;
  logic signed [31:0] tap_sel;
  logic signed [56:0] w_sel;
  logic signed [29:0] w_part;
  logic signed [61:0] prod;
  logic signed [95:0] prod_ext;
  logic signed [47:0] v;
  logic signed [47:0] v_bias;
  logic [33:0] y;
  logic [50:0] y_mul;
  logic [50:0] y_lo;
  logic [67:0] q_full;
  logic sat_hi, sat_lo;

  always_comb begin
    unique case (step[2:1])
      2'd0: begin tap_sel = taps[0]; w_sel = w0; end
      2'd1: begin tap_sel = taps[1]; w_sel = w1; end
      2'd2: begin tap_sel = taps[2]; w_sel = w2; end
      default: begin tap_sel = taps[3]; w_sel = w3; end
    endcase
    if (step[0]) w_part = {{2{w_sel[56]}}, w_sel[56:29]};
    else w_part = {1'b0, w_sel[28:0]};
    prod = 62'(tap_sel) * 62'(w_part);
    if (step[0]) prod_ext = {{5{prod[61]}}, prod, 29'd0};
    else prod_ext = {{34{prod[61]}}, prod};
    v = acc[95:48];
    // offset keeps the dividend non-negative inside the output range
    v_bias = v + SAT_BOUND;
    y_mul = 51'(y) * 51'((step == 4'd9) ? RECIP_3[16:0] : RECIP_3[33:17]);
    q_full = {y_mul, 17'd0} + 68'(y_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        acc <= 96'sd3 <<< 48;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step < 4'd8) begin
          acc <= acc + prod_ext;
        end else if (step == 4'd8) begin
          sat_hi <= v >= SAT_BOUND;
          sat_lo <= v < -SAT_BOUND;
          y <= v_bias[34:1];
        end else if (step == 4'd9) begin
          y_lo <= y_mul;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (sat_hi) begin
            value <= 32'sh7FFFFFFF; sat <= 1'b1;
          end else if (sat_lo) begin
            value <= 32'sh80000000; sat <= 1'b1;
          end else begin
            value <= q_full[66:35] ^ 32'h80000000; sat <= 1'b0;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/pspc_checker.sv @@
`timescale 1ns / 1ps
module pspc_checker
  import pspc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  input  wire logic               ready,
  input  wire logic [1:0]         func,
  input  wire logic [2:0]         dof_index,
  input  wire logic signed [31:0] sample_value,
  input  wire logic [16:0]        fraction,
  input  wire logic [1:0]         poly_order,
  input  wire logic               result_valid,
  input  wire logic               result_ready,
  input  wire logic signed [31:0] result_value,
  input  wire logic               saturated,
  output int                      errors,
  output int                      pending,
  output int                      n_results,
  output int                      n_sat
);
  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } outcome_t;

  row_t     hist [NUM_DOF];
  outcome_t exp_q[$];

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $time, what);
    errors++;
  endtask

  function automatic outcome_t lagrange_eval(row_t r, logic [1:0] fn, logic [16:0] frac,
                                             logic [1:0] ord);
    longint u, f, a, b, c, m, d;
    longint w[4];
    logic signed [127:0] acc, t128, w128, d128, q, rem;
    outcome_t o;
    u = 65536;
    f = (frac > FRAC_ONE) ? u : longint'(frac);
    a = u + f;
    b = 2 * u + f;
    c = 3 * u + f;
    m = u - f;
    d = 6 * u * u * u;
    w = '{0, 0, 0, 0};
    if (fn == FUNC_PREDICT) begin
      case (ord)
        2'd0: w[0] = d;
        2'd1: begin w[0] = 6 * u * u * a; w[1] = -6 * u * u * f; end
        2'd2: begin
          w[0] = 3 * u * a * b; w[1] = -6 * u * f * b; w[2] = 3 * u * f * a;
        end
        default: begin
          w[0] = a * b * c; w[1] = -3 * f * b * c; w[2] = 3 * f * a * c; w[3] = -f * a * b;
        end
      endcase
    end else begin
      case (ord)
        2'd0: w[0] = d;
        2'd1: begin w[0] = 6 * u * u * f; w[1] = 6 * u * u * m; end
        2'd2: begin
          w[0] = 3 * u * f * a; w[1] = 6 * u * m * a; w[2] = -3 * u * m * f;
        end
        default: begin
          w[0] = f * a * b; w[1] = 3 * m * a * b; w[2] = -3 * m * f * b; w[3] = m * f * a;
        end
      endcase
    end
    d128 = d;
    acc = d128 / 2;
    for (int k = 0; k < 4; k++) begin
      t128 = r[k];
      w128 = w[k];
      acc = acc + t128 * w128;
    end
    q = acc / d128;
    rem = acc % d128;
    if (rem != 0 && acc < 0) q = q - 1;
    if (q > 128'sd2147483647) begin
      o.value = 32'h7FFFFFFF; o.sat = 1'b1;
    end else if (q < -128'sd2147483648) begin
      o.value = 32'h80000000; o.sat = 1'b1;
    end else begin
      o.value = q[31:0]; o.sat = 1'b0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t o;
    if (rst) begin
      foreach (hist[i]) hist[i] <= '0;
      exp_q.delete();
      errors <= 0;
      pending <= 0;
      n_results <= 0;
      n_sat <= 0;
    end else begin
      if (valid && ready) begin
        case (func)
          FUNC_PUSH: hist[dof_index] <= {hist[dof_index][2:0], sample_value};
          FUNC_FILL: hist[dof_index] <= {4{sample_value}};
          default: exp_q.push_back(lagrange_eval(hist[dof_index], func, fraction,
                                                 poly_order));
        endcase
      end
      if (result_valid && result_ready) begin
        n_results <= n_results + 1;
        if (saturated) n_sat <= n_sat + 1;
        if (exp_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          o = exp_q.pop_front();
          if (result_value !== o.value)
            report($sformatf("result_value %0d, want %0d", result_value, o.value));
          if (saturated !== o.sat)
            report($sformatf("saturated %0b, want %0b", saturated, o.sat));
        end
      end
      pending <= exp_q.size();
    end
  end
endmodule

@@ tb/tb_polynomial_signal_predictor_corrector.sv @@
`timescale 1ns / 1ps
module tb_polynomial_signal_predictor_corrector;
  import pspc_pkg::*;

  logic clk = 0, rst = 1;
  logic valid = 0, result_ready = 0;
  logic [1:0] func = FUNC_PUSH;
  logic [2:0] dof_index = 0;
  logic signed [31:0] sample_value = 0;
  logic [16:0] fraction = 0;
  logic [1:0] poly_order = 0;
  wire ready, result_valid, saturated;
  wire signed [31:0] result_value;
  int errors, pending, n_results, n_sat;
  int n_req = 0;
  bit no_idle = 0;
  int quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  polynomial_signal_predictor_corrector u_top (.*);

  pspc_checker u_chk (.*);

  always @(posedge clk)
    result_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);

  always @(posedge clk) begin
    if ((valid && ready) || (result_valid && result_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] fn, input logic [2:0] dof,
                          input logic signed [31:0] s, input logic [16:0] fr,
                          input logic [1:0] ord);
    if (!no_idle && $urandom_range(99) < 33) begin
      valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    valid <= 1;
    func <= fn;
    dof_index <= dof;
    sample_value <= s;
    fraction <= fr;
    poly_order <= ord;
    do @(posedge clk); while (!ready);
    n_req++;
  endtask

  function automatic logic signed [31:0] rnd_sample();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $signed(32'($urandom_range(2000))) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rnd_frac();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return FRAC_ONE;
      2: return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // extremes, saturation both ways, fraction past one
    send_req(FUNC_FILL, 0, 32'h7FFFFFFF, 0, 0);
    send_req(FUNC_PREDICT, 0, 0, FRAC_ONE, 2'd3);
    send_req(FUNC_CORRECT, 0, 0, FRAC_ONE, 2'd3);
    send_req(FUNC_PUSH, 1, 32'h80000000, 0, 0);
    send_req(FUNC_PUSH, 1, 32'h7FFFFFFF, 0, 0);
    send_req(FUNC_PUSH, 1, 32'h80000000, 0, 0);
    send_req(FUNC_PUSH, 1, 32'h7FFFFFFF, 0, 0);
    for (int o = 0; o < 4; o++) begin
      send_req(FUNC_PREDICT, 1, 0, 17'h1FFFF, 2'(o));
      send_req(FUNC_CORRECT, 1, 0, 17'd32768, 2'(o));
    end
    send_req(FUNC_PREDICT, 7, 0, 17'd1, 2'd2);
    send_req(FUNC_FILL, 7, 32'hFFFFFFFF, 0, 0);
    send_req(FUNC_CORRECT, 7, 32'hFFFFFFFF, 0, 2'd1);
    send_req(FUNC_PREDICT, 0, 32'h80000000, FRAC_ONE, 2'd0);
    // wait for the pipeline to drain before the random part
    valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 600; i++) begin
      no_idle = (i >= 200 && i < 300);
      if (i == 400) begin
        valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(3) == 0)
        send_req(FUNC_FILL, 3'($urandom), rnd_sample(), 17'($urandom), 2'($urandom));
      else if ($urandom_range(1))
        send_req(FUNC_PUSH, 3'($urandom), rnd_sample(), 17'($urandom), 2'($urandom));
      else
        send_req($urandom_range(1) ? FUNC_PREDICT : FUNC_CORRECT, 3'($urandom),
                 32'($urandom), rnd_frac(), 2'($urandom));
    end
    no_idle = 0;
    valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d saturated",
             n_req, n_results, n_sat);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/pspc_pkg.sv
rtl/pspc_history_ram.sv
rtl/pspc_weights.sv
rtl/pspc_mac.sv
rtl/polynomial_signal_predictor_corrector.sv
tb/pspc_checker.sv
tb/tb_polynomial_signal_predictor_corrector.sv
